// File: hw/rtl/csc_pkg.sv
// shared types and constants for the climate sensor compensation block
package csc_pkg;

   // datapath word width, wide enough for every intermediate product
   localparam int unsigned DW = 128;

   // field widths
   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned RAW_W    = 20;
   localparam int unsigned VALUE_W  = 20;
   localparam int unsigned INDEX_W  = 3;
   localparam int unsigned CSR_W    = 64;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_TEMP  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_PRESS = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_HUMID = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NONE  = 2'd3;

   // register indexes
   localparam logic [INDEX_W-1:0] REG_TEMP_CAL  = 3'd0;
   localparam logic [INDEX_W-1:0] REG_PRESS_A   = 3'd1;
   localparam logic [INDEX_W-1:0] REG_PRESS_B   = 3'd2;
   localparam logic [INDEX_W-1:0] REG_PRESS_C   = 3'd3;
   localparam logic [INDEX_W-1:0] REG_HUMID_CAL = 3'd4;

   // divider quotient widths
   localparam int unsigned QW = 41;
   localparam logic [5:0] DIV_BITS_PQ  = 6'd41;
   localparam logic [5:0] DIV_BITS_OUT = 6'd20;

   // micro-operations of the compensation sequences
   typedef enum logic [5:0] {
      U_END,
      U_T_D, U_T_M1, U_T_M2, U_T_M3, U_T_FIN,
      U_P_A, U_P_M1, U_P_M2, U_P_M3, U_P_M4, U_P_M5, U_P_M6, U_P_M7,
      U_P_DIV1, U_P_M8, U_P_M9, U_P_M10, U_P_M11, U_P_DIV2,
      U_H_E, U_H_M1, U_H_M2, U_H_M3, U_H_M4, U_H_M5, U_H_M6, U_H_X,
      U_H_M7, U_H_M8, U_H_FIN
   } uop_type;

   typedef enum logic [1:0] {K_ALU, K_MUL, K_DIV, K_END} uop_kind_type;

   typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_DONE} ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic    load;
      logic    mul_start;
      logic    div_start;
      logic    write;
      logic    unavail;
      logic    emit;
      uop_type uop;
   } csc_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic p1_zero;
      logic d_zero;
   } csc_status_type;

endpackage

// File: hw/rtl/csc_channels.sv
// valid/ready channel interfaces for requests, responses and register writes

interface csc_req_if import csc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [RAW_W-1:0]    raw_reading;
   modport source (output valid, output opcode, output raw_reading, input ready);
   modport sink   (input valid, input opcode, input raw_reading, output ready);
endinterface

interface csc_rsp_if import csc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OPCODE_W-1:0]       quantity;
   logic signed [VALUE_W-1:0] value;
   logic                      pressure_unavailable;
   modport source (output valid, output quantity, output value, output pressure_unavailable,
                   input ready);
   modport sink   (input valid, input quantity, input value, input pressure_unavailable,
                   output ready);
endinterface

interface csc_csr_if import csc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index;
   logic [CSR_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/csc_mul.sv
// byte-serial signed multiplier, one multiplier byte per cycle
module csc_mul import csc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] a,
   input  logic [63:0]   b,
   output logic          done,
   output logic [DW-1:0] result
);

   logic          busy_ff, busy_in;
   logic          neg_ff, neg_in;
   logic [DW-1:0] mc_ff, mc_in;
   logic [63:0]   mq_ff, mq_in;
   logic [DW-1:0] acc_ff, acc_in;

   // finished once no multiplier bits remain
   assign done   = busy_ff && (mq_ff == 64'd0);
   assign result = neg_ff ? (DW'(0) - acc_ff) : acc_ff;

   // operand magnitudes, then one partial product per cycle
   always_comb begin
      busy_in = busy_ff;
      neg_in  = neg_ff;
      mc_in   = mc_ff;
      mq_in   = mq_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = a[DW-1] ^ b[63];
         mc_in   = a[DW-1] ? (DW'(0) - a) : a;
         mq_in   = b[63] ? (64'd0 - b) : b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (mq_ff == 64'd0) begin
            busy_in = 1'b0;
         end else begin
            acc_in = acc_ff + (mc_ff * DW'(mq_ff[7:0]));
            mc_in  = mc_ff << 8;
            mq_in  = mq_ff >> 8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      neg_ff <= neg_in;
      mc_ff  <= mc_in;
      mq_ff  <= mq_in;
      acc_ff <= acc_in;
   end

endmodule

// File: hw/rtl/csc_div.sv
// restoring divider with saturating quotient, one quotient bit per cycle
module csc_div import csc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [5:0]    bits,
   output logic          done,
   output logic [QW-1:0] quot
);

   logic          busy_ff, busy_in;
   logic          first_ff, first_in;
   logic          done_ff, done_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] ds_ff, ds_in;
   logic [QW-1:0] q_ff, q_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [5:0]    bits_ff, bits_in;
   logic          ge;
   logic [QW-1:0] sat_mask;

   assign ge       = rem_ff >= ds_ff;
   assign sat_mask = QW'((42'd1 << bits_ff) - 42'd1);
   assign done     = done_ff;
   assign quot     = q_ff;

   // first cycle checks for overflow, then one compare and subtract per bit
   always_comb begin
      busy_in  = busy_ff;
      first_in = first_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      ds_in    = ds_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      bits_in  = bits_ff;
      if (start) begin
         busy_in  = 1'b1;
         first_in = 1'b1;
         rem_in   = num;
         ds_in    = den << bits;
         q_in     = '0;
         cnt_in   = bits;
         bits_in  = bits;
      end else if (busy_ff) begin
         if (first_ff) begin
            if (ge) begin
               q_in    = sat_mask;
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               first_in = 1'b0;
               ds_in    = ds_ff >> 1;
            end
         end else begin
            if (ge) begin
               rem_in = rem_ff - ds_ff;
            end
            q_in   = {q_ff[QW-2:0], ge};
            ds_in  = ds_ff >> 1;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      first_ff <= first_in;
      rem_ff   <= rem_in;
      ds_ff    <= ds_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      bits_ff  <= bits_in;
   end

endmodule

// File: hw/rtl/csc_datapath.sv
// datapath: calibration registers, working registers, shared multiplier and divider
module csc_datapath import csc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  csc_cmd_type               cmd,
   output csc_status_type            status,
   input  logic [OPCODE_W-1:0]       req_opcode,
   input  logic [RAW_W-1:0]          req_raw,
   input  logic                      csr_write,
   input  logic [INDEX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]          csr_data,
   output logic [OPCODE_W-1:0]       rsp_quantity,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic                      rsp_unavail
);

   // sign extension helpers
   function automatic logic [DW-1:0] sx16(input logic [15:0] v);
      return {{(DW-16){v[15]}}, v};
   endfunction
   function automatic logic [DW-1:0] sx12(input logic [11:0] v);
      return {{(DW-12){v[11]}}, v};
   endfunction
   function automatic logic [DW-1:0] sx8(input logic [7:0] v);
      return {{(DW-8){v[7]}}, v};
   endfunction
   function automatic logic [DW-1:0] abs_w(input logic [DW-1:0] v);
      return v[DW-1] ? (DW'(0) - v) : v;
   endfunction
   // saturate to the result range
   function automatic logic [VALUE_W-1:0] clamp_value(input logic [DW-1:0] v);
      logic [VALUE_W-1:0] r;
      if ($signed(v) > 128'sd400000) begin
         r = VALUE_W'(400000);
      end else if ($signed(v) < -128'sd4000) begin
         r = VALUE_W'(-4000);
      end else begin
         r = v[VALUE_W-1:0];
      end
      return r;
   endfunction

   localparam logic [DW-1:0] DIV2_DEN = DW'(10582463) << 67;
   localparam logic [DW-1:0] ROUND66  = DW'(10582463) << 66;

   // calibration registers and stored fine temperature
   logic [47:0]        tcal_ff;
   logic [63:0]        pa_ff, pb_ff, hcal_ff;
   logic [15:0]        pc_ff;
   logic [RAW_W-1:0]   fine_ff, fine_in;

   // working registers
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [RAW_W-1:0]    raw_ff, raw_in;
   logic [DW-1:0]       ra_ff, ra_in, rb_ff, rb_in, rc_ff, rc_in;
   logic                neg_ff, neg_in;
   logic [VALUE_W-1:0]  res_ff, res_in;
   logic                unav_ff, unav_in;
   logic [OPCODE_W-1:0] out_q_ff;
   logic [VALUE_W-1:0]  out_v_ff;
   logic                out_u_ff;

   // shared units
   logic [DW-1:0] mul_a, mul_p;
   logic [63:0]   mul_b;
   logic          mul_done;
   logic [DW-1:0] div_num, div_den;
   logic [5:0]    div_bits;
   logic          div_done;
   logic [QW-1:0] div_q;

   csc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_p)
   );

   csc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .bits  (div_bits),
      .done  (div_done),
      .quot  (div_q)
   );

   // calibration fields
   logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2;
   logic [7:0]  h1, h3, h6;
   logic [11:0] h4, h5;
   assign t1 = tcal_ff[15:0];
   assign t2 = tcal_ff[31:16];
   assign t3 = tcal_ff[47:32];
   assign p1 = pa_ff[15:0];
   assign p2 = pa_ff[31:16];
   assign p3 = pa_ff[47:32];
   assign p4 = pa_ff[63:48];
   assign p5 = pb_ff[15:0];
   assign p6 = pb_ff[31:16];
   assign p7 = pb_ff[47:32];
   assign p8 = pb_ff[63:48];
   assign p9 = pc_ff;
   assign h1 = hcal_ff[7:0];
   assign h2 = hcal_ff[23:8];
   assign h3 = hcal_ff[31:24];
   assign h4 = hcal_ff[43:32];
   assign h5 = hcal_ff[55:44];
   assign h6 = hcal_ff[63:56];

   logic [DW-1:0] fine_w;
   assign fine_w = {{(DW-RAW_W){fine_ff[RAW_W-1]}}, fine_ff};

   assign status.mul_done = mul_done;
   assign status.div_done = div_done;
   assign status.p1_zero  = (p1 == 16'd0);
   assign status.d_zero   = (rb_ff == '0);

   // temperature finish: truncated fine value and rounded output
   logic [DW-1:0]      tf_mag, tf_s, t_sum, t_val;
   logic [RAW_W-1:0]   tf_fine;
   assign tf_mag = abs_w(ra_ff) >> 34;
   assign tf_s   = ra_ff[DW-1] ? (DW'(0) - tf_mag) : tf_mag;
   always_comb begin
      if ($signed(tf_s) > 128'sd524287) begin
         tf_fine = RAW_W'(524287);
      end else if ($signed(tf_s) < -128'sd524288) begin
         tf_fine = RAW_W'(-524288);
      end else begin
         tf_fine = tf_s[RAW_W-1:0];
      end
   end
   assign t_sum = (ra_ff << 3) + ra_ff + (DW'(1) << 41);
   assign t_val = DW'($signed(t_sum) >>> 42) + DW'(3200);

   // humidity intermediate and finish
   logic [DW-1:0] hx_mag, hx_sat, hx, hq;
   logic [VALUE_W-1:0] h_val;
   assign hx_mag = abs_w(ra_ff) >> 62;
   assign hx_sat = (hx_mag > ((DW'(1) << 40) - DW'(1))) ? ((DW'(1) << 40) - DW'(1)) : hx_mag;
   assign hx     = ra_ff[DW-1] ? (DW'(0) - hx_sat) : hx_sat;
   assign hq     = (rc_ff + (DW'(1) << 48)) >> 49;
   assign h_val  = rc_ff[DW-1] ? '0 :
                   ((hq > DW'(102400)) ? VALUE_W'(102400) : hq[VALUE_W-1:0]);

   // pressure quotients with sign
   logic [DW-1:0] dq, dq_s;
   assign dq   = DW'(div_q);
   assign dq_s = neg_ff ? (DW'(0) - dq) : dq;

   logic [DW-1:0] p_w;
   assign p_w = (DW'(1) << 20) - DW'(raw_ff);

   // multiplier and divider operand selection
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      div_num  = ra_ff;
      div_den  = rb_ff;
      div_bits = DIV_BITS_PQ;
      case (cmd.uop)
         U_T_M1:   begin mul_a = ra_ff;        mul_b = 64'(sx16(t2));   end
         U_T_M2:   begin mul_a = ra_ff;        mul_b = ra_ff[63:0];     end
         U_T_M3:   begin mul_a = rc_ff;        mul_b = 64'(sx16(t3));   end
         U_P_M1:   begin mul_a = ra_ff;        mul_b = ra_ff[63:0];     end
         U_P_M2:   begin mul_a = rb_ff;        mul_b = 64'(sx16(p6));   end
         U_P_M3:   begin mul_a = ra_ff;        mul_b = 64'(sx16(p5));   end
         U_P_M4:   begin mul_a = rb_ff;        mul_b = 64'(sx16(p3));   end
         U_P_M5:   begin mul_a = ra_ff;        mul_b = 64'(sx16(p2));   end
         U_P_M6:   begin mul_a = abs_w(rc_ff); mul_b = 64'd6250;        end
         U_P_M7:   begin mul_a = abs_w(rb_ff); mul_b = 64'(p1);         end
         U_P_M8:   begin mul_a = rc_ff;        mul_b = 64'(sx16(p9));   end
         U_P_M9:   begin mul_a = ra_ff;        mul_b = rc_ff[63:0];     end
         U_P_M10:  begin mul_a = rc_ff;        mul_b = 64'(sx16(p8));   end
         U_P_M11:  begin mul_a = abs_w(rb_ff); mul_b = 64'd31250000;    end
         U_P_DIV2: begin div_den = DIV2_DEN;   div_bits = DIV_BITS_OUT; end
         U_H_M1:   begin mul_a = ra_ff;        mul_b = 64'(sx12(h5));   end
         U_H_M2:   begin mul_a = ra_ff;        mul_b = 64'(h3);         end
         U_H_M3:   begin mul_a = rb_ff;        mul_b = ra_ff[63:0];     end
         U_H_M4:   begin mul_a = rb_ff;        mul_b = 64'(sx8(h6));    end
         U_H_M5:   begin mul_a = rc_ff;        mul_b = 64'(sx16(h2));   end
         U_H_M6:   begin mul_a = rc_ff;        mul_b = rb_ff[63:0];     end
         U_H_M7:   begin mul_a = ra_ff;        mul_b = 64'(h1);         end
         U_H_M8:   begin mul_a = rb_ff;        mul_b = ra_ff[63:0];     end
         default:  begin end
      endcase
   end

   // register updates per micro-operation
   always_comb begin
      op_in   = op_ff;
      raw_in  = raw_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      rc_in   = rc_ff;
      neg_in  = neg_ff;
      fine_in = fine_ff;
      res_in  = res_ff;
      unav_in = unav_ff;
      if (cmd.load) begin
         op_in   = req_opcode;
         raw_in  = req_raw;
         res_in  = '0;
         unav_in = 1'b0;
      end
      if (cmd.unavail) begin
         unav_in = 1'b1;
      end
      if (cmd.write) begin
         case (cmd.uop)
            U_T_D:    ra_in = DW'(raw_ff) - (DW'(t1) << 4);
            U_T_M1:   rb_in = mul_p << 20;
            U_T_M2:   rc_in = mul_p;
            U_T_M3:   ra_in = rb_ff + mul_p;
            U_T_FIN:  begin
               fine_in = tf_fine;
               res_in  = clamp_value(t_val);
            end
            U_P_A:    ra_in = fine_w - DW'(128000);
            U_P_M1:   rb_in = mul_p;
            U_P_M2:   rc_in = (p_w << 31) - mul_p - (sx16(p4) << 35);
            U_P_M3:   rc_in = rc_ff - (mul_p << 17);
            U_P_M4:   rb_in = (DW'(1) << 55) + mul_p;
            U_P_M5:   rb_in = rb_ff + (mul_p << 20);
            U_P_M6:   begin
               ra_in  = mul_p << 40;
               neg_in = rc_ff[DW-1] ^ rb_ff[DW-1];
            end
            U_P_M7:   rb_in = mul_p;
            U_P_DIV1: rc_in = dq_s;
            U_P_M8:   ra_in = mul_p;
            U_P_M9:   rb_in = (rc_ff << 51) + mul_p;
            U_P_M10:  rb_in = rb_ff + (mul_p << 32) + (sx16(p7) << 63);
            U_P_M11:  begin
               ra_in  = mul_p + ROUND66;
               neg_in = rb_ff[DW-1];
            end
            U_P_DIV2: res_in = clamp_value(dq_s);
            U_H_E:    begin
               ra_in = fine_w - DW'(76800);
               rc_in = (DW'(raw_ff) << 14) - (sx12(h4) << 20);
            end
            U_H_M1:   rc_in = rc_ff - mul_p;
            U_H_M2:   rb_in = mul_p + (DW'(1) << 26);
            U_H_M3:   rb_in = mul_p;
            U_H_M4:   rb_in = mul_p + (DW'(1) << 52);
            U_H_M5:   rc_in = mul_p;
            U_H_M6:   ra_in = mul_p;
            U_H_X:    ra_in = hx;
            U_H_M7:   rb_in = mul_p;
            U_H_M8:   rc_in = (ra_ff << 39) - mul_p;
            U_H_FIN:  res_in = h_val;
            default:  begin end
         endcase
      end
   end

   // state with reset: calibration and fine temperature
   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff <= '0;
         pa_ff   <= '0;
         pb_ff   <= '0;
         pc_ff   <= '0;
         hcal_ff <= '0;
         fine_ff <= '0;
      end else begin
         fine_ff <= fine_in;
         if (csr_write) begin
            case (csr_index)
               REG_TEMP_CAL:  tcal_ff <= csr_data[47:0];
               REG_PRESS_A:   pa_ff   <= csr_data;
               REG_PRESS_B:   pb_ff   <= csr_data;
               REG_PRESS_C:   pc_ff   <= csr_data[15:0];
               REG_HUMID_CAL: hcal_ff <= csr_data;
               default:       begin end
            endcase
         end
      end
   end

   // working and output payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      raw_ff  <= raw_in;
      ra_ff   <= ra_in;
      rb_ff   <= rb_in;
      rc_ff   <= rc_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
      unav_ff <= unav_in;
      if (cmd.emit) begin
         out_q_ff <= op_ff;
         out_v_ff <= res_ff;
         out_u_ff <= unav_ff;
      end
   end

   assign rsp_quantity = out_q_ff;
   assign rsp_value    = out_v_ff;
   assign rsp_unavail  = out_u_ff;

endmodule

// File: hw/rtl/csc_ctrl.sv
// controller: sequences micro-operations and runs the channel handshakes
module csc_ctrl import csc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OPCODE_W-1:0] req_opcode,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  csc_status_type      status,
   output csc_cmd_type         cmd
);

   function automatic uop_kind_type uop_kind(input uop_type u);
      uop_kind_type k;
      case (u)
         U_T_D, U_T_FIN, U_P_A, U_H_E, U_H_X, U_H_FIN: k = K_ALU;
         U_P_DIV1, U_P_DIV2:                          k = K_DIV;
         U_END:                                       k = K_END;
         default:                                     k = K_MUL;
      endcase
      return k;
   endfunction

   function automatic uop_type uop_next(input uop_type u);
      uop_type n;
      case (u)
         U_T_D:    n = U_T_M1;
         U_T_M1:   n = U_T_M2;
         U_T_M2:   n = U_T_M3;
         U_T_M3:   n = U_T_FIN;
         U_P_A:    n = U_P_M1;
         U_P_M1:   n = U_P_M2;
         U_P_M2:   n = U_P_M3;
         U_P_M3:   n = U_P_M4;
         U_P_M4:   n = U_P_M5;
         U_P_M5:   n = U_P_M6;
         U_P_M6:   n = U_P_M7;
         U_P_M7:   n = U_P_DIV1;
         U_P_DIV1: n = U_P_M8;
         U_P_M8:   n = U_P_M9;
         U_P_M9:   n = U_P_M10;
         U_P_M10:  n = U_P_M11;
         U_P_M11:  n = U_P_DIV2;
         U_H_E:    n = U_H_M1;
         U_H_M1:   n = U_H_M2;
         U_H_M2:   n = U_H_M3;
         U_H_M3:   n = U_H_M4;
         U_H_M4:   n = U_H_M5;
         U_H_M5:   n = U_H_M6;
         U_H_M6:   n = U_H_X;
         U_H_X:    n = U_H_M7;
         U_H_M7:   n = U_H_M8;
         U_H_M8:   n = U_H_FIN;
         default:  n = U_END;
      endcase
      return n;
   endfunction

   function automatic uop_type first_uop(input logic [OPCODE_W-1:0] op);
      uop_type u;
      case (op)
         OP_TEMP:  u = U_T_D;
         OP_PRESS: u = U_P_A;
         OP_HUMID: u = U_H_E;
         default:  u = U_END;
      endcase
      return u;
   endfunction

   ctrl_state_type state_ff, state_in;
   uop_type        uop_ff, uop_in;
   logic           rsp_valid_ff, rsp_valid_in;
   uop_type        nxt;

   assign nxt       = uop_next(uop_ff);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      uop_in       = uop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.uop      = uop_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               uop_in   = first_uop(req_opcode);
               state_in = (req_opcode == OP_NONE) ? ST_DONE : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if ((uop_ff == U_P_A && status.p1_zero) || (uop_ff == U_P_M6 && status.d_zero)) begin
               cmd.unavail = 1'b1;
               state_in    = ST_DONE;
            end else begin
               case (uop_kind(uop_ff))
                  K_ALU: begin
                     cmd.write = 1'b1;
                     uop_in    = nxt;
                     state_in  = (nxt == U_END) ? ST_DONE : ST_EXEC;
                  end
                  K_MUL: begin
                     cmd.mul_start = 1'b1;
                     state_in      = ST_MUL;
                  end
                  K_DIV: begin
                     cmd.div_start = 1'b1;
                     state_in      = ST_DIV;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_MUL: begin
            if (status.mul_done) begin
               cmd.write = 1'b1;
               uop_in    = nxt;
               state_in  = (nxt == U_END) ? ST_DONE : ST_EXEC;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.write = 1'b1;
               uop_in    = nxt;
               state_in  = (nxt == U_END) ? ST_DONE : ST_EXEC;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         uop_ff       <= U_END;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         uop_ff       <= uop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/climate_sensor_compensation.sv
// top level of the climate sensor compensation block
//
//   channel  direction  transfer carries
//   req      in         opcode, raw_reading
//   rsp      out        quantity, value, pressure_unavailable
//   csr      in         index, data (register write, always ready)
//
// one item at a time; the next item is taken while a result waits in the output register;
// a pressure item ends early as unavailable when p1 is zero or the divisor is zero, opcode
// three goes straight to the result; a finished item then waits until the previous result
// is taken; items run on the shared multiplier (one multiplier byte per cycle) and the
// divider (one quotient bit per cycle, 41 then 20 bits for pressure)
// synchronous reset clears calibration, fine temperature and all control state
module climate_sensor_compensation import csc_pkg::*; (
   input logic    clock,
   input logic    reset,
   csc_req_if.sink   req,
   csc_rsp_if.source rsp,
   csc_csr_if.sink   csr
);

   csc_cmd_type    cmd;
   csc_status_type status;
   logic           req_ready;
   logic           rsp_valid;

   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;
   assign csr.ready = 1'b1;

   csc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_opcode (req.opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp.ready),
      .status     (status),
      .cmd        (cmd)
   );

   csc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_opcode   (req.opcode),
      .req_raw      (req.raw_reading),
      .csr_write    (csr.valid),
      .csr_index    (csr.index),
      .csr_data     (csr.data),
      .rsp_quantity (rsp.quantity),
      .rsp_value    (rsp.value),
      .rsp_unavail  (rsp.pressure_unavailable)
   );

endmodule

// File: tb/climate_sensor_compensation_tb.sv
// testbench for the climate sensor compensation block: table-driven and random readings
module climate_sensor_compensation_tb;
   import csc_pkg::*;

   typedef logic signed [255:0] wide_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] quantity;
      logic [VALUE_W-1:0]  value;
      logic                unavail;
   } reading_type;

   typedef struct {
      int unsigned         stage;
      logic [OPCODE_W-1:0] opcode;
      logic [RAW_W-1:0]    raw;
      bit                  pinned;
      logic [VALUE_W-1:0]  value;
      bit                  unavail;
   } stim_row_type;

   localparam logic [INDEX_W-1:0] REG_SPARE = 3'd7;
   localparam int unsigned N_DIRECTED = 24;
   localparam int unsigned N_PHASES = 10;
   localparam int unsigned PHASE_ITEMS = 143;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES = 250;

   // typical factory calibration words
   localparam logic [47:0] TYP_TEMP    = {16'hFC18, 16'h6743, 16'h6B70};
   localparam logic [63:0] TYP_PRESS_A = {16'h0B27, 16'h0BD0, 16'hD643, 16'h8E7D};
   localparam logic [63:0] TYP_PRESS_B = {16'hC6F8, 16'h3C8C, 16'hFFF9, 16'h008C};
   localparam logic [15:0] TYP_PRESS_C = 16'h1770;
   localparam logic [63:0] TYP_HUMID   = {8'h1E, 12'h032, 12'h139, 8'h00, 16'h016A, 8'h4B};

   logic clock = 1'b0;
   logic reset = 1'b1;

   csc_req_if req_if();
   csc_rsp_if rsp_if();
   csc_csr_if csr_if();

   climate_sensor_compensation dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .csr(csr_if)
   );

   always #1 clock = ~clock;

   // calibration and state copies
   logic [47:0]        cal_temp;
   logic [63:0]        cal_press_a;
   logic [63:0]        cal_press_b;
   logic [15:0]        cal_press_c;
   logic [63:0]        cal_humid;
   logic signed [19:0] fine_temp;

   reading_type expected_q[$];
   int unsigned errors = 0;
   int unsigned results_seen = 0;
   bit calm = 1'b0;
   bit pin_en = 1'b0;
   reading_type pin_res;

   stim_row_type directed[N_DIRECTED] = '{
      // reset calibration: every coefficient zero
      '{0, OP_TEMP,  20'h00000, 1, 20'd3200, 0},
      '{0, OP_TEMP,  20'hFFFFF, 1, 20'd3200, 0},
      '{0, OP_PRESS, 20'h00000, 1, 20'd0,    1},
      '{0, OP_PRESS, 20'hFFFFF, 1, 20'd0,    1},
      '{0, OP_HUMID, 20'h00000, 1, 20'd0,    0},
      '{0, OP_HUMID, 20'hFFFFF, 1, 20'd0,    0},
      '{0, OP_NONE,  20'h00000, 1, 20'd0,    0},
      '{0, OP_NONE,  20'hFFFFF, 1, 20'd0,    0},
      // typical calibration, humidity and pressure before any temperature
      '{1, OP_HUMID, 20'h06A00, 0, 20'd0, 0},
      '{1, OP_PRESS, 20'h50000, 0, 20'd0, 0},
      '{1, OP_TEMP,  20'h7E000, 0, 20'd0, 0},
      '{1, OP_PRESS, 20'h50000, 0, 20'd0, 0},
      '{1, OP_PRESS, 20'h00000, 0, 20'd0, 0},
      '{1, OP_PRESS, 20'hFFFFF, 0, 20'd0, 0},
      '{1, OP_HUMID, 20'h00000, 0, 20'd0, 0},
      '{1, OP_HUMID, 20'h0FFFF, 0, 20'd0, 0},
      '{1, OP_HUMID, 20'hFFFFF, 0, 20'd0, 0},
      '{1, OP_NONE,  20'h12345, 0, 20'd0, 0},
      '{1, OP_TEMP,  20'h00000, 0, 20'd0, 0},
      '{1, OP_PRESS, 20'h60000, 0, 20'd0, 0},
      '{1, OP_HUMID, 20'h07000, 0, 20'd0, 0},
      '{1, OP_TEMP,  20'hFFFFF, 0, 20'd0, 0},
      '{1, OP_PRESS, 20'h40000, 0, 20'd0, 0},
      '{1, OP_HUMID, 20'h05000, 0, 20'd0, 0}
   };

   function automatic wide_type clamp(wide_type v, wide_type lo, wide_type hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // compensation of one reading; a temperature updates the fine temperature
   function automatic reading_type compensate(logic [OPCODE_W-1:0] op, logic [RAW_W-1:0] raw);
      wide_type one, t1, t2, t3, d, num, f, v;
      wide_type p1, p2, p3, p4, p5, p6, p7, p8, p9, a, p, n, dn, pq, s, m, num2, den;
      wide_type h1, h2, h3, h4, h5, h6, e, an, bn, prod, x, h;
      reading_type r;
      one = 1;
      r.quantity = op;
      r.unavail = 1'b0;
      v = 0;
      case (op)
         OP_TEMP: begin
            t1 = wide_type'(cal_temp[15:0]);
            t2 = wide_type'($signed(cal_temp[31:16]));
            t3 = wide_type'($signed(cal_temp[47:32]));
            d = wide_type'(raw) - 16 * t1;
            num = ((d * t2) <<< 20) + d * d * t3;
            f = (num < 0 ? -num : num) >>> 34;
            if (num < 0) f = -f;
            fine_temp = 20'(clamp(f, -524288, 524287));
            v = clamp(((9 * num + (one <<< 41)) >>> 42) + 3200, -4000, 400000);
         end
         OP_PRESS: begin
            p1 = wide_type'(cal_press_a[15:0]);
            p2 = wide_type'($signed(cal_press_a[31:16]));
            p3 = wide_type'($signed(cal_press_a[47:32]));
            p4 = wide_type'($signed(cal_press_a[63:48]));
            p5 = wide_type'($signed(cal_press_b[15:0]));
            p6 = wide_type'($signed(cal_press_b[31:16]));
            p7 = wide_type'($signed(cal_press_b[47:32]));
            p8 = wide_type'($signed(cal_press_b[63:48]));
            p9 = wide_type'($signed(cal_press_c));
            a = wide_type'(fine_temp) - 128000;
            p = (one <<< 20) - wide_type'(raw);
            n = (p <<< 31) - a * a * p6 - ((a * p5) <<< 17) - (p4 <<< 35);
            dn = (one <<< 55) + p3 * a * a + ((p2 * a) <<< 20);
            if (p1 == 0 || dn == 0) begin
               r.unavail = 1'b1;
            end else begin
               pq = (((n < 0 ? -n : n) * 6250) <<< 40) / (p1 * (dn < 0 ? -dn : dn));
               if (pq > (one <<< 41) - 1) pq = (one <<< 41) - 1;
               if ((n < 0) != (dn < 0)) pq = -pq;
               s = (pq <<< 51) + p9 * pq * pq + ((p8 * pq) <<< 32) + (p7 <<< 63);
               m = s < 0 ? -s : s;
               num2 = m * 31250000 + (wide_type'(10582463) <<< 66);
               den = wide_type'(10582463) <<< 67;
               v = num2 / den;
               if (v > (one <<< 20) - 1) v = (one <<< 20) - 1;
               if (s < 0) v = -v;
               v = clamp(v, -4000, 400000);
            end
         end
         OP_HUMID: begin
            h1 = wide_type'(cal_humid[7:0]);
            h2 = wide_type'($signed(cal_humid[23:8]));
            h3 = wide_type'(cal_humid[31:24]);
            h4 = wide_type'($signed(cal_humid[43:32]));
            h5 = wide_type'($signed(cal_humid[55:44]));
            h6 = wide_type'($signed(cal_humid[63:56]));
            e = wide_type'(fine_temp) - 76800;
            an = (wide_type'(raw) <<< 14) - (h4 <<< 20) - h5 * e;
            bn = (one <<< 52) + h6 * e * ((one <<< 26) + h3 * e);
            prod = an * h2 * bn;
            x = (prod < 0 ? -prod : prod) >>> 62;
            if (x > (one <<< 40) - 1) x = (one <<< 40) - 1;
            if (prod < 0) x = -x;
            h = (x <<< 39) - h1 * x * x;
            if (h < 0) v = 0;
            else begin
               v = (h + (one <<< 48)) >>> 49;
               if (v > 102400) v = 102400;
            end
         end
         default: v = 0;
      endcase
      r.value = v[VALUE_W-1:0];
      return r;
   endfunction

   // observe every transfer on the three channels
   always @(posedge clock) begin
      reading_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result q=%0d v=%0d u=%0b",
                  rsp_if.quantity, rsp_if.value, rsp_if.pressure_unavailable);
            end else begin
               want = expected_q.pop_front();
               if (rsp_if.quantity !== want.quantity || rsp_if.value !== want.value ||
                   rsp_if.pressure_unavailable !== want.unavail) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected q=%0d v=%0d u=%0b, got q=%0d v=%0d u=%0b",
                        want.quantity, $signed(want.value), want.unavail, rsp_if.quantity,
                        rsp_if.value, rsp_if.pressure_unavailable);
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            want = compensate(req_if.opcode, req_if.raw_reading);
            expected_q.push_back(pin_en ? pin_res : want);
         end
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               REG_TEMP_CAL:  cal_temp    = csr_if.data[47:0];
               REG_PRESS_A:   cal_press_a = csr_if.data;
               REG_PRESS_B:   cal_press_b = csr_if.data;
               REG_PRESS_C:   cal_press_c = csr_if.data[15:0];
               REG_HUMID_CAL: cal_humid   = csr_if.data;
               default: ;
            endcase
         end
      end
   end

   // result side: random stalls, and one long hold-off to back the block up
   initial begin
      int unsigned gap;
      bit held;
      held = 1'b0;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 6);
         if (!held && results_seen >= 150) begin
            held = 1'b1;
            gap = HOLD_OFF_CYCLES;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         @(negedge clock);
      end
   end

   task automatic send_reading(logic [OPCODE_W-1:0] op, logic [RAW_W-1:0] raw);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.opcode <= op;
      req_if.raw_reading <= raw;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // valid stays high after the transfer; the caller drops it after its last write
   task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= data;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
   endtask

   // let every outstanding reading come back before touching calibration
   task automatic drain();
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic load_calibration(logic [47:0] t, logic [63:0] pa, logic [63:0] pb,
                                   logic [15:0] pc, logic [63:0] hu);
      drain();
      write_reg(REG_TEMP_CAL, {16'h0, t});
      write_reg(REG_PRESS_A, pa);
      write_reg(REG_PRESS_B, pb);
      write_reg(REG_PRESS_C, {48'h0, pc});
      write_reg(REG_HUMID_CAL, hu);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // stimulus
   initial begin
      logic [OPCODE_W-1:0] op;
      logic [RAW_W-1:0] raw;
      logic [63:0] mask;
      int unsigned pick;
      req_if.valid = 1'b0;
      req_if.opcode = OP_TEMP;
      req_if.raw_reading = '0;
      csr_if.valid = 1'b0;
      csr_if.index = REG_TEMP_CAL;
      csr_if.data = '0;
      cal_temp = '0;
      cal_press_a = '0;
      cal_press_b = '0;
      cal_press_c = '0;
      cal_humid = '0;
      fine_temp = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (int unsigned i = 0; i < N_DIRECTED; i++) begin
         if (i > 0 && directed[i].stage != directed[i-1].stage) begin
            pin_en <= 1'b0;
            load_calibration(TYP_TEMP, TYP_PRESS_A, TYP_PRESS_B, TYP_PRESS_C, TYP_HUMID);
            csr_if.valid <= 1'b0;
         end
         pin_en <= directed[i].pinned;
         pin_res <= '{directed[i].opcode, directed[i].value, directed[i].unavail};
         send_reading(directed[i].opcode, directed[i].raw);
      end
      pin_en <= 1'b0;

      // random phases, each under its own calibration
      for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
         calm = (ph == 0 || $urandom_range(0, 3) == 0);
         mask = 64'h001F_001F_001F_001F;
         case (ph)
            1: load_calibration('1, '1, '1, '1, '1);
            2: load_calibration('0, '0, '0, '0, '0);
            3: load_calibration(48'(rand64()), rand64(), rand64(), 16'($urandom), rand64());
            4: load_calibration(TYP_TEMP ^ 48'(rand64() & mask),
                  {TYP_PRESS_A[63:16], 16'h0}, TYP_PRESS_B, TYP_PRESS_C, TYP_HUMID);
            default: load_calibration(TYP_TEMP ^ 48'(rand64() & mask),
                  TYP_PRESS_A ^ (rand64() & mask), TYP_PRESS_B ^ (rand64() & mask),
                  TYP_PRESS_C ^ 16'($urandom & 32'h1F), TYP_HUMID ^ (rand64() & mask));
         endcase
         if (ph == 1) write_reg(REG_SPARE, rand64());
         csr_if.valid <= 1'b0;
         for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(0, 9);
            op = pick < 3 ? OP_TEMP : pick < 6 ? OP_PRESS : pick < 9 ? OP_HUMID : OP_NONE;
            case ($urandom_range(0, 7))
               0: raw = $urandom_range(0, 1) ? '1 : '0;
               1, 2, 3: raw = 20'($urandom);
               default: raw = op == OP_HUMID ? 20'($urandom_range(20'h4000, 20'h9000))
                                             : 20'($urandom_range(20'h60000, 20'h90000));
            endcase
            send_reading(op, raw);
         end
      end

      // wind down
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("climate_sensor_compensation_tb: done, clean");
      end else begin
         $display("climate_sensor_compensation_tb: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("climate_sensor_compensation_tb: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/csc_pkg.sv
hw/rtl/csc_channels.sv
hw/rtl/csc_mul.sv
hw/rtl/csc_div.sv
hw/rtl/csc_datapath.sv
hw/rtl/csc_ctrl.sv
hw/rtl/climate_sensor_compensation.sv
tb/climate_sensor_compensation_tb.sv
